// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros for the barometer compensation checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// Property whose consequent must hold in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Property whose consequent must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/bpc_pkg.sv =====
`timescale 1ns / 1ps

package bpc_pkg;

	// Register indexes on the configuration port (address bits 4:3).
	localparam logic [1:0] REG_TEMP_CAL = 2'd0;
	localparam logic [1:0] REG_PRESS_A  = 2'd1;
	localparam logic [1:0] REG_PRESS_B  = 2'd2;
	localparam logic [1:0] REG_PRESS_C  = 2'd3;

	// One divider stage retires one quotient bit.
	localparam int DIV_STEPS = 64;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] fine_temperature;
		logic signed [31:0] temperature_centi;
		logic [31:0]        pressure_q24_8;
		logic               divide_by_zero;
	} result_t;

endpackage

// ===== rtl/core/barometric_pressure_compensation_core.sv =====
`timescale 1ns / 1ps

// Barometer compensation pipeline. Each beat on the sample channel carries one raw 20-bit
// temperature and one raw 20-bit pressure conversion; the core returns one result beat with
// the fine temperature, the temperature in 0.01 degC and the pressure in Q24.8 pascals, using
// the datasheet 64-bit integer formulas with the calibration words held in four registers
// (APB, 64-bit data, register i at byte address 8*i). A new sample is taken every clock unless
// the pipeline is halted, and each sample passes through 11 stages of temperature and pressure
// arithmetic, 64 restoring divider stages (one quotient bit per stage), and 6 stages of final
// pressure correction. The whole pipeline halts while a result waits on result_ready.
// Calibration registers are only to be written while no sample is in flight.
module barometric_pressure_compensation_core
	import bpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  sample_t     sample,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	// Calibration registers.
	logic [47:0] temp_cal_q;
	logic [63:0] press_a_q;
	logic [63:0] press_b_q;
	logic [15:0] press_c_q;

	logic        cfg_wr;
	logic [1:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q <= '0;
			press_a_q  <= '0;
			press_b_q  <= '0;
			press_c_q  <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_TEMP_CAL: temp_cal_q <= pwdata[47:0];
				REG_PRESS_A:  press_a_q  <= pwdata;
				REG_PRESS_B:  press_b_q  <= pwdata;
				REG_PRESS_C:  press_c_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (cfg_idx)
			REG_TEMP_CAL: prdata = {16'd0, temp_cal_q};
			REG_PRESS_A:  prdata = press_a_q;
			REG_PRESS_B:  prdata = press_b_q;
			REG_PRESS_C:  prdata = {48'd0, press_c_q};
			default:      prdata = '0;
		endcase
	end

	// Calibration coefficients.
	logic [15:0]        t1;
	logic signed [15:0] t2, t3;
	logic [15:0]        p1;
	logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = temp_cal_q[15:0];
	assign t2 = $signed(temp_cal_q[31:16]);
	assign t3 = $signed(temp_cal_q[47:32]);
	assign p1 = press_a_q[15:0];
	assign p2 = $signed(press_a_q[31:16]);
	assign p3 = $signed(press_a_q[47:32]);
	assign p4 = $signed(press_a_q[63:48]);
	assign p5 = $signed(press_b_q[15:0]);
	assign p6 = $signed(press_b_q[31:16]);
	assign p7 = $signed(press_b_q[47:32]);
	assign p8 = $signed(press_b_q[63:48]);
	assign p9 = $signed(press_c_q);

	// The whole pipeline moves when the output register is empty or being drained.
	logic adv;
	assign adv          = !result_valid || result_ready;
	assign sample_ready = adv;

	// Stage valid bits.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic vld_s11, vld_s13, vld_s14, vld_s15, vld_s16, vld_s17, vld_s18;
	logic dv_vld_s12 [DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
			vld_s17 <= 1'b0;
			vld_s18 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= sample_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s13 <= dv_vld_s12[DIV_STEPS-1];
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			vld_s16 <= vld_s15;
			vld_s17 <= vld_s16;
			vld_s18 <= vld_s17;
		end
	end

	// Temperature path, 32-bit wrapping arithmetic.
	logic signed [31:0] ta_s1, td_s1;
	logic [19:0]        adp_s1, adp_s2, adp_s3, adp_s4, adp_s5, adp_s6, adp_s7, adp_s8;
	logic signed [31:0] amul_s2, ddm_s2;
	logic signed [31:0] a_s3, bmul_s3;
	logic signed [31:0] fine_s4;
	logic signed [31:0] cm_s5;
	logic signed [33:0] v1_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			ta_s1   <= $signed({15'd0, sample.raw_temperature[19:3]} - {15'd0, t1, 1'b0});
			td_s1   <= $signed({16'd0, sample.raw_temperature[19:4]} - {16'd0, t1});
			adp_s1  <= sample.raw_pressure;
			amul_s2 <= ta_s1 * t2;
			ddm_s2  <= td_s1 * td_s1;
			adp_s2  <= adp_s1;
			a_s3    <= amul_s2 >>> 11;
			bmul_s3 <= (ddm_s2 >>> 12) * t3;
			adp_s3  <= adp_s2;
			fine_s4 <= a_s3 + (bmul_s3 >>> 14);
			adp_s4  <= adp_s3;
			cm_s5   <= fine_s4 * 32'sd5 + 32'sd128;
			v1_s5   <= 34'(fine_s4) - 34'sd128000;
			adp_s5  <= adp_s4;
		end
	end

	// Pressure path up to the divider, 64-bit wrapping arithmetic.
	logic signed [31:0] fine_s5, fine_s6, fine_s7, fine_s8, fine_s9, fine_s10, fine_s11;
	logic signed [31:0] centi_s6, centi_s7, centi_s8, centi_s9, centi_s10, centi_s11;
	logic signed [63:0] vsq_s6, v1p5_s6, v1p2_s6;
	logic signed [63:0] v2a_s7, v3a_s7, v1p5_s7, v1p2_s7;
	logic signed [63:0] v2_s8, xx_s8;
	logic signed [63:0] y_s9, num0_s9;
	logic signed [30:0] den_s10;
	logic signed [63:0] num_s10;
	logic               zero_s11, neg_s11;
	logic [63:0]        an_s11;
	logic [30:0]        ad_s11;
	logic [20:0]        pdiff;

	assign pdiff = 21'h10_0000 - {1'b0, adp_s8};

	always_ff @(posedge clk) begin
		if (adv) begin
			fine_s5   <= fine_s4;
			centi_s6  <= cm_s5 >>> 8;
			vsq_s6    <= 64'(v1_s5) * 64'(v1_s5);
			v1p5_s6   <= 64'(v1_s5) * p5;
			v1p2_s6   <= 64'(v1_s5) * p2;
			fine_s6   <= fine_s5;
			adp_s6    <= adp_s5;
			v2a_s7    <= vsq_s6 * p6;
			v3a_s7    <= vsq_s6 * p3;
			v1p5_s7   <= v1p5_s6;
			v1p2_s7   <= v1p2_s6;
			fine_s7   <= fine_s6;
			centi_s7  <= centi_s6;
			adp_s7    <= adp_s6;
			v2_s8     <= v2a_s7 + (v1p5_s7 <<< 17) + (64'(p4) <<< 35);
			xx_s8     <= 64'sh0000_8000_0000_0000 + (v3a_s7 >>> 8) + (v1p2_s7 <<< 12);
			fine_s8   <= fine_s7;
			centi_s8  <= centi_s7;
			adp_s8    <= adp_s7;
			y_s9      <= xx_s8 * $signed({1'b0, p1});
			num0_s9   <= $signed({12'd0, pdiff, 31'd0}) - v2_s8;
			fine_s9   <= fine_s8;
			centi_s9  <= centi_s8;
			den_s10   <= y_s9[63:33];
			num_s10   <= num0_s9 * 64'sd3125;
			fine_s10  <= fine_s9;
			centi_s10 <= centi_s9;
			zero_s11  <= (den_s10 == 31'sd0);
			neg_s11   <= num_s10[63] ^ den_s10[30];
			an_s11    <= num_s10[63] ? 64'(-num_s10) : 64'(num_s10);
			ad_s11    <= den_s10[30] ? 31'(-den_s10) : 31'(den_s10);
			fine_s11  <= fine_s10;
			centi_s11 <= centi_s10;
		end
	end

	// Restoring divider: each stage shifts in one numerator bit and decides one quotient bit.
	logic [30:0]        dv_rem_s12   [DIV_STEPS];
	logic [63:0]        dv_nq_s12    [DIV_STEPS];
	logic [30:0]        dv_ad_s12    [DIV_STEPS];
	logic               dv_neg_s12   [DIV_STEPS];
	logic               dv_zero_s12  [DIV_STEPS];
	logic signed [31:0] dv_fine_s12  [DIV_STEPS];
	logic signed [31:0] dv_centi_s12 [DIV_STEPS];

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		logic [30:0]        src_rem;
		logic [63:0]        src_nq;
		logic [30:0]        src_ad;
		logic               src_vld, src_neg, src_zero;
		logic signed [31:0] src_fine, src_centi;
		logic [31:0]        trial;
		logic               ge;

		if (i == 0) begin : g_first
			assign src_rem   = '0;
			assign src_nq    = an_s11;
			assign src_ad    = ad_s11;
			assign src_vld   = vld_s11;
			assign src_neg   = neg_s11;
			assign src_zero  = zero_s11;
			assign src_fine  = fine_s11;
			assign src_centi = centi_s11;
		end else begin : g_next
			assign src_rem   = dv_rem_s12[i-1];
			assign src_nq    = dv_nq_s12[i-1];
			assign src_ad    = dv_ad_s12[i-1];
			assign src_vld   = dv_vld_s12[i-1];
			assign src_neg   = dv_neg_s12[i-1];
			assign src_zero  = dv_zero_s12[i-1];
			assign src_fine  = dv_fine_s12[i-1];
			assign src_centi = dv_centi_s12[i-1];
		end

		assign trial = {src_rem, src_nq[63]};
		assign ge    = trial >= {1'b0, src_ad};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s12[i] <= 1'b0;
			end else if (adv) begin
				dv_vld_s12[i] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s12[i]   <= ge ? 31'(trial - {1'b0, src_ad}) : trial[30:0];
				dv_nq_s12[i]    <= {src_nq[62:0], ge};
				dv_ad_s12[i]    <= src_ad;
				dv_neg_s12[i]   <= src_neg;
				dv_zero_s12[i]  <= src_zero;
				dv_fine_s12[i]  <= src_fine;
				dv_centi_s12[i] <= src_centi;
			end
		end
	end

	// Final correction: signed quotient, squared term and offsets.
	logic signed [63:0] p_s13, p_s14, p_s15, p_s16;
	logic signed [63:0] ps;
	logic [63:0]        ll_s14;
	logic [31:0]        hl_s14;
	logic signed [63:0] w2m_s14;
	logic signed [63:0] sq_s15, w2_s15, w2_s16;
	logic signed [63:0] w1m_s16;
	logic signed [63:0] s_s17;
	logic [31:0]        press_s18;
	logic               zero_s13, zero_s14, zero_s15, zero_s16, zero_s17, zero_s18;
	logic signed [31:0] fine_s13, fine_s14, fine_s15, fine_s16, fine_s17, fine_s18;
	logic signed [31:0] centi_s13, centi_s14, centi_s15, centi_s16, centi_s17, centi_s18;

	assign ps = p_s13 >>> 13;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s13     <= dv_neg_s12[DIV_STEPS-1] ? $signed(-dv_nq_s12[DIV_STEPS-1])
			                                     : $signed(dv_nq_s12[DIV_STEPS-1]);
			zero_s13  <= dv_zero_s12[DIV_STEPS-1];
			fine_s13  <= dv_fine_s12[DIV_STEPS-1];
			centi_s13 <= dv_centi_s12[DIV_STEPS-1];
			// Low half squared plus the cross term; the high half squared drops out mod 2^64.
			ll_s14    <= 64'(ps[31:0]) * 64'(ps[31:0]);
			hl_s14    <= ps[31:0] * ps[63:32];
			w2m_s14   <= p_s13 * p8;
			p_s14     <= p_s13;
			zero_s14  <= zero_s13;
			fine_s14  <= fine_s13;
			centi_s14 <= centi_s13;
			sq_s15    <= $signed(ll_s14 + {hl_s14[30:0], 33'd0});
			w2_s15    <= w2m_s14 >>> 19;
			p_s15     <= p_s14;
			zero_s15  <= zero_s14;
			fine_s15  <= fine_s14;
			centi_s15 <= centi_s14;
			w1m_s16   <= sq_s15 * p9;
			w2_s16    <= w2_s15;
			p_s16     <= p_s15;
			zero_s16  <= zero_s15;
			fine_s16  <= fine_s15;
			centi_s16 <= centi_s15;
			s_s17     <= p_s16 + (w1m_s16 >>> 25) + w2_s16;
			zero_s17  <= zero_s16;
			fine_s17  <= fine_s16;
			centi_s17 <= centi_s16;
			press_s18 <= zero_s17 ? 32'd0
			                      : s_s17[39:8] + {{12{p7[15]}}, p7, 4'd0};
			zero_s18  <= zero_s17;
			fine_s18  <= fine_s17;
			centi_s18 <= centi_s17;
		end
	end

	// Output register.
	assign result_valid             = vld_s18;
	assign result.fine_temperature  = fine_s18;
	assign result.temperature_centi = centi_s18;
	assign result.pressure_q24_8    = press_s18;
	assign result.divide_by_zero    = zero_s18;

endmodule

// ===== rtl/core/bpc_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks on the compensation core.
module bpc_checker
	import bpc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        sample_ready,
	input logic        result_valid,
	input logic        result_ready,
	input result_t     result
);

	logic               zero_beat;
	logic signed [31:0] centi_expect;

	assign zero_beat    = result_valid && result.divide_by_zero;
	assign centi_expect = 32'(($signed(result.fine_temperature) * 32'sd5 + 32'sd128) >>> 8);

	// A stalled result beat holds.
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))
	// A zero divisor always forces the pressure to zero.
	`ASSERT_IMPLIES(a_div_zero, clk, arst_n, zero_beat, result.pressure_q24_8 == 32'd0)
	// The centidegree output follows from the fine temperature of the same beat.
	`ASSERT_IMPLIES(a_centi, clk, arst_n, result_valid, result.temperature_centi == centi_expect)
	// The core takes a sample whenever no result is stuck at the output.
	`ASSERT_IMPLIES(a_ready, clk, arst_n, !result_valid || result_ready, sample_ready)

endmodule

bind barometric_pressure_compensation_core bpc_checker u_bpc_checker (.*);
